@@ src/itp_pkg.sv @@
// ---------------------------------------------------------------------------
// itp_pkg: shared types, constants and helper functions
// Payload structs, parse phases, status codes and character classes for the
// integer text parser.
// ---------------------------------------------------------------------------
package itp_pkg;

  // Widths fixed by the interface
  localparam int CHAR_W        = 8;
  localparam int VALUE_W       = 64;
  localparam int END_W         = 16;
  localparam int STATUS_W      = 2;
  localparam int BASE_W        = 6;
  localparam int DIGIT_W       = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 6;
  localparam int POSITION_BITS_DEF = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINARY_PREFIX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE   = 2'd2;

  // Radix values
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  // Digit value for a byte that is no digit at all
  localparam logic [DIGIT_W-1:0] NO_DIGIT = 7'd99;

  // Characters
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HT      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_X    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_B    = 8'h42;
  localparam logic [CHAR_W-1:0] CH_LO_B    = 8'h62;

  // Clamp values
  localparam logic [VALUE_W-1:0] SIGNED_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] SIGNED_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS,
    PH_DONE,
    PH_INVALID
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NO_DIGITS,
    ST_RANGE,
    ST_BAD_BASE
  } status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  parsed_value;
    logic [END_W-1:0]    end_position;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Raw outcome of one string, before clamping and sign handling
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic               minus;
    logic               ovf;
    status_t            status;
    logic [END_W-1:0]   endp;
  } finish_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = CHAR_W'(NO_DIGIT);
    if ((c >= CH_0) && (c <= CH_9)) begin
      d = c - CH_0;
    end else if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
      d = c - CH_LO_A + CHAR_W'(BASE_DEC);
    end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      d = c - CH_UP_A + CHAR_W'(BASE_DEC);
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

@@ src/integer_text_parser_top.sv @@
// ---------------------------------------------------------------------------
// integer_text_parser_top: streaming strtoll / strtoull style integer parser
// Takes one byte request per cycle, skips leading white space, takes an
// optional sign and a 0x (or, when enabled, 0b) prefix, accumulates digits
// of base 2..36 into 64 bits with overflow detection, and on the byte marked
// last returns value, end offset and status. The block sustains one byte
// per clock unless a last byte waits for room in the finish register;
// a string's result passes the finish register, then the result register.
// The per-byte work is one 64 x 6 bit multiply-add by the base plus the
// saturating position counter, which sets the cycle time. Config writes are
// only legal while no string is in flight; number_base is latched at a
// string's first byte, binary_prefix_enable is read at the byte after a
// leading zero and signed_mode when the finished string is clamped.
// ---------------------------------------------------------------------------
module integer_text_parser_top #(
  parameter int POSITION_BITS = itp_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  itp_pkg::in_item_t             in_data,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output itp_pkg::out_item_t            out_data,
  // configuration
  input  logic                          cfg_we,
  input  logic [itp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [itp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int VW   = itp_pkg::VALUE_W;
  localparam int EW   = itp_pkg::END_W;
  localparam int ExtW = (POSITION_BITS > EW) ? POSITION_BITS : EW;
  localparam int ProdW = VW + itp_pkg::BASE_W;

  // ---- configuration registers ----
  logic [itp_pkg::BASE_W-1:0] number_base_r;
  logic                       bin_pfx_r;
  logic                       signed_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= itp_pkg::BASE_DEC;
      bin_pfx_r     <= 1'b0;
      signed_mode_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        itp_pkg::CFG_NUMBER_BASE:   number_base_r <= cfg_wdata[itp_pkg::BASE_W-1:0];
        itp_pkg::CFG_BINARY_PREFIX: bin_pfx_r     <= cfg_wdata[0];
        itp_pkg::CFG_SIGNED_MODE:   signed_mode_r <= cfg_wdata[0];
        default: ;  // index beyond the register list: drop
      endcase
    end
  end

  // ---- pipeline handshake ----
  // Stage flow: input register -> parse step -> finish register -> clamp
  // and sign -> result register. Only last bytes enter the finish stage.
  logic              in_valid_r;
  itp_pkg::in_item_t in_data_r;
  logic              fin_valid_r;
  itp_pkg::finish_t  fin_r;
  logic              out_valid_r;
  itp_pkg::out_item_t out_data_r;

  logic out_free, fin_free, proc;

  assign out_free = !out_valid_r || out_ready;
  assign fin_free = !fin_valid_r || out_free;
  // Advance the held byte; a last byte also needs room in the finish stage
  assign proc     = in_valid_r && (!in_data_r.last_byte || fin_free);
  assign in_ready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // ---- parse state ----
  itp_pkg::phase_t             phase_r, phase_nxt;
  logic [VW-1:0]               acc_r, acc_nxt;
  logic [itp_pkg::BASE_W-1:0]  wb_r, wb_nxt;
  logic                        minus_r, minus_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        digits_r, digits_nxt;
  logic [POSITION_BITS-1:0]    bpos_r, bpos_nxt;
  logic [POSITION_BITS-1:0]    stop_r, stop_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= itp_pkg::PH_SPACE;
      acc_r    <= '0;
      wb_r     <= '0;
      minus_r  <= 1'b0;
      ovf_r    <= 1'b0;
      digits_r <= 1'b0;
      bpos_r   <= '0;
      stop_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      wb_r     <= wb_nxt;
      minus_r  <= minus_nxt;
      ovf_r    <= ovf_nxt;
      digits_r <= digits_nxt;
      bpos_r   <= bpos_nxt;
      stop_r   <= stop_nxt;
    end
  end

  // ---- decode of the held byte ----
  logic [itp_pkg::CHAR_W-1:0]  c;
  logic [itp_pkg::DIGIT_W-1:0] dval;
  logic                        base_bad;
  logic [POSITION_BITS-1:0]    pos_inc;

  assign c        = in_data_r.char_byte;
  assign dval     = itp_pkg::digit_of(c);
  assign base_bad = (number_base_r == itp_pkg::BASE_ONE) ||
                    (number_base_r > itp_pkg::BASE_MAX);
  // Saturate the offset at the counter width
  assign pos_inc  = (bpos_r == '1) ? bpos_r : bpos_r + 1'b1;

  // ---- phase decision: which radix and whether a digit step runs ----
  itp_pkg::phase_t            ph_eff, ph_step;
  logic [itp_pkg::BASE_W-1:0] wb_eff, wb_step, b_use;
  logic                       minus_step, do_digit, zero_lead;

  always_comb begin : step_comb
    ph_eff = phase_r;
    wb_eff = wb_r;
    // Latch the radix at the first byte of a string
    if ((bpos_r == '0) && (phase_r == itp_pkg::PH_SPACE)) begin
      if (base_bad) begin
        ph_eff = itp_pkg::PH_INVALID;
      end else begin
        wb_eff = number_base_r;
      end
    end
    ph_step    = ph_eff;
    wb_step    = wb_eff;
    b_use      = wb_eff;
    minus_step = minus_r;
    do_digit   = 1'b0;
    zero_lead  = 1'b0;
    unique case (ph_eff)
      itp_pkg::PH_SPACE, itp_pkg::PH_SIGNED: begin
        priority if ((ph_eff == itp_pkg::PH_SPACE) && itp_pkg::is_blank(c)) begin
          // hold: skip white space
        end else if ((ph_eff == itp_pkg::PH_SPACE) &&
                     ((c == itp_pkg::CH_PLUS) || (c == itp_pkg::CH_MINUS))) begin
          minus_step = (c == itp_pkg::CH_MINUS);
          ph_step    = itp_pkg::PH_SIGNED;
        end else if (c == itp_pkg::CH_0) begin
          zero_lead = 1'b1;
        end else begin
          do_digit = 1'b1;
          b_use    = (wb_eff == itp_pkg::BASE_AUTO) ? itp_pkg::BASE_DEC : wb_eff;
          wb_step  = b_use;
        end
      end
      itp_pkg::PH_ZERO: begin
        priority if (((c == itp_pkg::CH_LO_X) || (c == itp_pkg::CH_UP_X)) &&
                     ((wb_eff == itp_pkg::BASE_AUTO) || (wb_eff == itp_pkg::BASE_HEX))) begin
          wb_step = itp_pkg::BASE_HEX;
          ph_step = itp_pkg::PH_PREFIX;
        end else if (bin_pfx_r && ((c == itp_pkg::CH_LO_B) || (c == itp_pkg::CH_UP_B)) &&
                     ((wb_eff == itp_pkg::BASE_AUTO) || (wb_eff == itp_pkg::BASE_BIN))) begin
          wb_step = itp_pkg::BASE_BIN;
          ph_step = itp_pkg::PH_PREFIX;
        end else begin
          do_digit = 1'b1;
          b_use    = (wb_eff == itp_pkg::BASE_AUTO) ? itp_pkg::BASE_OCT : wb_eff;
          wb_step  = b_use;
        end
      end
      itp_pkg::PH_PREFIX, itp_pkg::PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: ;  // parse over or base invalid: drop the byte
    endcase
  end

  // ---- multiply-add by the radix ----
  logic             digit_ok, prod_ovf;
  logic [ProdW-1:0] prod;

  assign digit_ok = (b_use >= itp_pkg::BASE_BIN) && (dval < {1'b0, b_use});
  assign prod     = ProdW'(acc_r) * ProdW'(b_use) + ProdW'(dval);
  assign prod_ovf = |prod[ProdW-1:VW];

  // ---- state after this byte ----
  itp_pkg::phase_t          ph_upd;
  logic [VW-1:0]            acc_upd;
  logic                     ovf_upd, digits_upd;
  logic [POSITION_BITS-1:0] stop_upd;

  always_comb begin : update_comb
    ph_upd     = ph_step;
    acc_upd    = acc_r;
    ovf_upd    = ovf_r;
    digits_upd = digits_r;
    stop_upd   = stop_r;
    if (zero_lead) begin
      acc_upd    = '0;
      digits_upd = 1'b1;
      stop_upd   = pos_inc;
      ph_upd     = itp_pkg::PH_ZERO;
    end else if (do_digit) begin
      if (digit_ok) begin
        if (prod_ovf) begin
          ovf_upd = 1'b1;
        end else begin
          acc_upd = prod[VW-1:0];
        end
        digits_upd = 1'b1;
        stop_upd   = pos_inc;
        ph_upd     = itp_pkg::PH_DIGITS;
      end else begin
        ph_upd = itp_pkg::PH_DONE;
      end
    end
  end

  // Commit the step; the last byte returns everything to the start state
  always_comb begin : next_comb
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    wb_nxt     = wb_r;
    minus_nxt  = minus_r;
    ovf_nxt    = ovf_r;
    digits_nxt = digits_r;
    bpos_nxt   = bpos_r;
    stop_nxt   = stop_r;
    if (proc) begin
      if (in_data_r.last_byte) begin
        phase_nxt  = itp_pkg::PH_SPACE;
        acc_nxt    = '0;
        wb_nxt     = '0;
        minus_nxt  = 1'b0;
        ovf_nxt    = 1'b0;
        digits_nxt = 1'b0;
        bpos_nxt   = '0;
        stop_nxt   = '0;
      end else begin
        phase_nxt  = ph_upd;
        acc_nxt    = acc_upd;
        wb_nxt     = wb_step;
        minus_nxt  = minus_step;
        ovf_nxt    = ovf_upd;
        digits_nxt = digits_upd;
        bpos_nxt   = pos_inc;
        stop_nxt   = stop_upd;
      end
    end
  end

  // ---- finish record for a last byte ----
  itp_pkg::finish_t fin_nxt;
  logic [ExtW-1:0]  stop_ext;

  assign stop_ext = ExtW'(stop_upd);

  always_comb begin : finish_comb
    fin_nxt.acc    = acc_upd;
    fin_nxt.minus  = minus_step;
    fin_nxt.ovf    = ovf_upd;
    fin_nxt.endp   = '0;
    if (ph_upd == itp_pkg::PH_INVALID) begin
      fin_nxt.status = itp_pkg::ST_BAD_BASE;
    end else if (!digits_upd) begin
      fin_nxt.status = itp_pkg::ST_NO_DIGITS;
    end else begin
      fin_nxt.status = itp_pkg::ST_OK;
      fin_nxt.endp   = stop_ext[EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_free) begin
      fin_valid_r <= proc && in_data_r.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_free && proc && in_data_r.last_byte) begin
      fin_r <= fin_nxt;
    end
  end

  // ---- clamp, saturate and apply the sign ----
  logic [VW-1:0]    limit, res_value;
  logic             signed_range;
  itp_pkg::status_t res_status;

  assign limit        = fin_r.minus ? itp_pkg::SIGNED_MIN : itp_pkg::SIGNED_MAX;
  // Magnitude above the limit: top bit set, and for minus also any lower bit
  assign signed_range = fin_r.ovf || (fin_r.acc[VW-1] &&
                        (!fin_r.minus || (|fin_r.acc[VW-2:0])));

  always_comb begin : result_comb
    res_value  = '0;
    res_status = fin_r.status;
    if (fin_r.status == itp_pkg::ST_OK) begin
      priority if (signed_mode_r && signed_range) begin
        res_status = itp_pkg::ST_RANGE;
        res_value  = limit;
      end else if (!signed_mode_r && fin_r.ovf) begin
        res_status = itp_pkg::ST_RANGE;
        res_value  = '1;
      end else begin
        res_value = fin_r.minus ? ('0 - fin_r.acc) : fin_r.acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_valid_r) begin
      out_data_r.parsed_value <= res_value;
      out_data_r.end_position <= fin_r.endp;
      out_data_r.status       <= res_status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- assertions ----
  // A last byte returns the parser to the start of a new string
  assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_data_r.last_byte |=> (phase_r == itp_pkg::PH_SPACE) && (bpos_r == '0))
    else $error("parser state not cleared after last byte");

  // Before any digit beyond a leading zero the accumulator stays empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == itp_pkg::PH_SPACE) || (phase_r == itp_pkg::PH_SIGNED) ||
    (phase_r == itp_pkg::PH_ZERO) || (phase_r == itp_pkg::PH_PREFIX)
    |-> (acc_r == '0) && !ovf_r)
    else $error("accumulator loaded before digit run");

  // A result with bad base or no digits carries value and offset zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.status == itp_pkg::ST_BAD_BASE) ||
                  (out_data.status == itp_pkg::ST_NO_DIGITS))
    |-> (out_data.parsed_value == '0) && (out_data.end_position == '0))
    else $error("failed parse reports nonzero value or offset");

endmodule
